/* sv/sces_pkg.sv */
// Package for the supercapacitor enable sequencer.
// Holds the configuration and result types, the register indexes and the reset values.
// No dependencies.
`timescale 1ns / 1ps

package sces_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned EnCntW   = 16;
  localparam int unsigned RfCntW   = 8;
  localparam int unsigned DisCntW  = 10;

  localparam logic [CfgIdxW-1:0] REG_ENABLE_DELAY     = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_REFRESH_PERIOD   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DISABLE_DEBOUNCE = 2'd2;

  localparam logic [EnCntW-1:0]  ENABLE_DELAY_RST     = 16'd1000;
  localparam logic [RfCntW-1:0]  REFRESH_PERIOD_RST   = 8'd10;
  localparam logic [DisCntW-1:0] DISABLE_DEBOUNCE_RST = 10'd30;

  typedef struct packed {
    logic [EnCntW-1:0]  enable_delay;
    logic [RfCntW-1:0]  refresh_period;
    logic [DisCntW-1:0] disable_debounce;
  } sces_cfg_t;

  typedef struct packed {
    logic send_command;
    logic use_capacitor;
    logic enabled_now;
  } sces_result_t;

endpackage

/* sv/sces_stream_if.sv */
// Valid/ready channel interfaces of the sequencer: tick input and command output.
// Standalone, no package dependency.
`timescale 1ns / 1ps

interface sces_in_if;
  logic valid;
  logic ready;
  logic output_allowed;

  modport source (output valid, output output_allowed, input ready);
  modport sink   (input valid, input output_allowed, output ready);
endinterface

interface sces_out_if;
  logic valid;
  logic ready;
  logic send_command;
  logic use_capacitor;
  logic enabled_now;

  modport source (output valid, output send_command, output use_capacitor,
                  output enabled_now, input ready);
  modport sink   (input valid, input send_command, input use_capacitor,
                  input enabled_now, output ready);
endinterface

/* sv/sces_cfg_regs.sv */
// Configuration register file: enable delay, refresh period, disable debounce.
// Depends on sces_pkg.
`timescale 1ns / 1ps

module sces_cfg_regs
  import sces_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output sces_cfg_t           cfg_o
);

  sces_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENABLE_DELAY:     cfg_d.enable_delay     = cfg_data_i[EnCntW-1:0];
        REG_REFRESH_PERIOD:   cfg_d.refresh_period   = cfg_data_i[RfCntW-1:0];
        REG_DISABLE_DEBOUNCE: cfg_d.disable_debounce = cfg_data_i[DisCntW-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_delay     <= ENABLE_DELAY_RST;
      cfg_q.refresh_period   <= REFRESH_PERIOD_RST;
      cfg_q.disable_debounce <= DISABLE_DEBOUNCE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/sces_core.sv */
// Sequencer state: enabled flag and the enable, refresh and debounce counters.
// Advances one tick per step strobe; result is combinational. Depends on sces_pkg.
`timescale 1ns / 1ps

module sces_core
  import sces_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic         allowed_i,
  input  sces_cfg_t    cfg_i,
  output sces_result_t res_o
);

  logic               enabled_q, enabled_d;
  logic [EnCntW-1:0]  en_cnt_q, en_cnt_d;
  logic [RfCntW-1:0]  rf_cnt_q, rf_cnt_d;
  logic [DisCntW-1:0] dis_cnt_q, dis_cnt_d;

  logic [EnCntW:0]  en_nxt;
  logic [RfCntW:0]  rf_nxt;
  logic [DisCntW:0] dis_nxt;
  logic             en_hit, rf_hit, dis_hit;

  // compare one bit wider so the count never wraps
  assign en_nxt  = {1'b0, en_cnt_q} + {{EnCntW{1'b0}}, 1'b1};
  assign rf_nxt  = {1'b0, rf_cnt_q} + {{RfCntW{1'b0}}, 1'b1};
  assign dis_nxt = {1'b0, dis_cnt_q} + {{DisCntW{1'b0}}, 1'b1};
  assign en_hit  = en_nxt  >= {1'b0, cfg_i.enable_delay};
  assign rf_hit  = rf_nxt  >= {1'b0, cfg_i.refresh_period};
  assign dis_hit = dis_nxt >= {1'b0, cfg_i.disable_debounce};

  always_comb begin
    enabled_d           = enabled_q;
    en_cnt_d            = en_cnt_q;
    rf_cnt_d            = rf_cnt_q;
    dis_cnt_d           = dis_cnt_q;
    res_o.send_command  = 1'b0;
    res_o.use_capacitor = 1'b0;
    if (allowed_i) begin
      dis_cnt_d = '0;
      if (!enabled_q) begin
        rf_cnt_d = '0;
        if (en_hit) begin
          en_cnt_d            = '0;
          enabled_d           = 1'b1;
          res_o.send_command  = 1'b1;
          res_o.use_capacitor = 1'b1;
        end else begin
          en_cnt_d = en_nxt[EnCntW-1:0];
        end
      end else if (rf_hit) begin
        rf_cnt_d            = '0;
        res_o.send_command  = 1'b1;
        res_o.use_capacitor = 1'b1;
      end else begin
        rf_cnt_d = rf_nxt[RfCntW-1:0];
      end
    end else begin
      en_cnt_d = '0;
      rf_cnt_d = '0;
      if (enabled_q) begin
        if (dis_hit) begin
          dis_cnt_d          = '0;
          enabled_d          = 1'b0;
          res_o.send_command = 1'b1;
        end else begin
          dis_cnt_d = dis_nxt[DisCntW-1:0];
        end
      end else begin
        dis_cnt_d = '0;
      end
    end
    res_o.enabled_now = enabled_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
      en_cnt_q  <= '0;
      rf_cnt_q  <= '0;
      dis_cnt_q <= '0;
    end else if (step_i) begin
      enabled_q <= enabled_d;
      en_cnt_q  <= en_cnt_d;
      rf_cnt_q  <= rf_cnt_d;
      dis_cnt_q <= dis_cnt_d;
    end
  end

endmodule

/* sv/supercap_enable_sequencer_unit.sv */
// channel   dir  handshake     word
// in_i      in   valid/ready   output_allowed
// out_o     out  valid/ready   send_command, use_capacitor, enabled_now
// cfg       in   cfg_we_i      cfg_idx_i, cfg_data_i (no read-back)
//
// One word per cycle sustained while out_o is ready; an accepted word lands in the
// input register, then moves on into the result register that drives out_o. State
// advances when the input word moves into the result register. A stalled
// result holds while the input register still takes one more word. Reset
// clears state and loads the register defaults.
// Depends on sces_pkg, sces_stream_if, sces_cfg_regs, sces_core.
`timescale 1ns / 1ps

module supercap_enable_sequencer_unit
  import sces_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  sces_in_if.sink             in_i,
  sces_out_if.source          out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  sces_cfg_t    cfg;
  sces_result_t res;
  sces_result_t res_q;
  logic         in_valid_q, allowed_q;
  logic         out_valid_q;
  logic         step, in_ready;

  assign step     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || step;
  assign in_i.ready = in_ready;

  sces_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sces_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .allowed_i (allowed_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_i.valid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      allowed_q <= in_i.output_allowed;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.send_command  = res_q.send_command;
  assign out_o.use_capacitor = res_q.use_capacitor;
  assign out_o.enabled_now   = res_q.enabled_now;

  a_enable_cmd_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.send_command && res_q.use_capacitor |-> res_q.enabled_now)
    else $error("enable command with capacitor off");

  a_disable_cmd_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.send_command && !res_q.use_capacitor |-> !res_q.enabled_now)
    else $error("disable command with capacitor on");

  a_use_needs_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.send_command |-> !res_q.use_capacitor)
    else $error("use flag set without command");

  a_flag_change_sends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (res.enabled_now != u_core.enabled_q) |-> res.send_command)
    else $error("enable flag changed without command");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for supercap_enable_sequencer_unit: drives control ticks and
// register writes, predicts each command word and compares it field by field.
// Depends on sces_pkg, sces_stream_if and the sequencer RTL.
`timescale 1ns / 1ps

module testbench
  import sces_pkg::*;
;

  localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT  = 1500000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned PHASE_COUNT  = 7;

  // Tracks enable/refresh/debounce state and queues the expected command words.
  class cmd_scoreboard;
    logic [EnCntW-1:0]  enable_delay;
    logic [RfCntW-1:0]  refresh_period;
    logic [DisCntW-1:0] disable_debounce;
    logic               enabled;
    logic [EnCntW-1:0]  enable_cnt;
    logic [RfCntW-1:0]  refresh_cnt;
    logic [DisCntW-1:0] disable_cnt;
    sces_result_t       pending[$];
    int unsigned        errors;

    function new();
      enable_delay     = ENABLE_DELAY_RST;
      refresh_period   = REFRESH_PERIOD_RST;
      disable_debounce = DISABLE_DEBOUNCE_RST;
      enabled          = 1'b0;
      enable_cnt       = '0;
      refresh_cnt      = '0;
      disable_cnt      = '0;
      errors           = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        REG_ENABLE_DELAY:     enable_delay     = data[EnCntW-1:0];
        REG_REFRESH_PERIOD:   refresh_period   = data[RfCntW-1:0];
        REG_DISABLE_DEBOUNCE: disable_debounce = data[DisCntW-1:0];
        default: ;
      endcase
    endfunction

    // count + 1 compared one bit wider than the counter, so it never wraps
    function bit limit_hit(int unsigned count, int unsigned limit);
      return (count + 1) >= limit;
    endfunction

    function void note_tick(logic allowed);
      sces_result_t cmd;
      cmd = '0;
      if (allowed) begin
        disable_cnt = '0;
        if (!enabled) begin
          refresh_cnt = '0;
          if (limit_hit(32'(enable_cnt), 32'(enable_delay))) begin
            enable_cnt = '0;
            enabled = 1'b1;
            cmd.send_command = 1'b1;
            cmd.use_capacitor = 1'b1;
          end else begin
            enable_cnt = enable_cnt + 1'b1;
          end
        end else if (limit_hit(32'(refresh_cnt), 32'(refresh_period))) begin
          refresh_cnt = '0;
          cmd.send_command = 1'b1;
          cmd.use_capacitor = 1'b1;
        end else begin
          refresh_cnt = refresh_cnt + 1'b1;
        end
      end else begin
        enable_cnt  = '0;
        refresh_cnt = '0;
        if (enabled) begin
          if (limit_hit(32'(disable_cnt), 32'(disable_debounce))) begin
            disable_cnt = '0;
            enabled = 1'b0;
            cmd.send_command = 1'b1;
          end else begin
            disable_cnt = disable_cnt + 1'b1;
          end
        end else begin
          disable_cnt = '0;
        end
      end
      cmd.enabled_now = enabled;
      pending.push_back(cmd);
    endfunction

    function void check_cmd(sces_result_t got);
      sces_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected command word, actual %b", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.send_command !== exp.send_command) begin
        $display("%0t: send_command expected %b actual %b", $time,
                 exp.send_command, got.send_command);
        errors++;
      end
      if (got.use_capacitor !== exp.use_capacitor) begin
        $display("%0t: use_capacitor expected %b actual %b", $time,
                 exp.use_capacitor, got.use_capacitor);
        errors++;
      end
      if (got.enabled_now !== exp.enabled_now) begin
        $display("%0t: enabled_now expected %b actual %b", $time,
                 exp.enabled_now, got.enabled_now);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  sces_in_if  in_ch ();
  sces_out_if out_ch ();

  cmd_scoreboard sb = new();

  bit          tx_gaps_on;
  bit          rx_stalls_on;
  bit          rx_hold_req;
  int unsigned cycle_count;

  supercap_enable_sequencer_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("supercap_enable_sequencer_unit test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) sb.note_tick(in_ch.output_allowed);
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      sb.check_cmd('{send_command:  out_ch.send_command,
                     use_capacitor: out_ch.use_capacitor,
                     enabled_now:   out_ch.enabled_now});
    end
  end

  // a toggle of rx_hold_req starts one long hold
  initial begin : result_sink
    int unsigned stall_left;
    bit          hold_seen;
    stall_left   = 0;
    hold_seen    = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_req != hold_seen) begin
        hold_seen  = rx_hold_req;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (rx_stalls_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_tick(input logic allowed);
    int unsigned gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.output_allowed <= 1'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.output_allowed <= allowed;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_run(input logic allowed, input int unsigned len);
    repeat (len) send_tick(allowed);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // upper data bits beyond a register's width are random and must be dropped
  task automatic configure(input logic [EnCntW-1:0] ed, input logic [RfCntW-1:0] rp,
                           input logic [DisCntW-1:0] dd);
    write_reg(REG_UNUSED, 16'($urandom));
    write_reg(REG_ENABLE_DELAY, ed);
    write_reg(REG_REFRESH_PERIOD, {8'($urandom), rp});
    write_reg(REG_DISABLE_DEBOUNCE, {6'($urandom), dd});
    cfg_we_i <= 1'b0;
  endtask

  // mostly allowed/disallowed runs around the thresholds, some bursts of one to eight random ticks
  task automatic run_sequences(input int unsigned n_items, input int unsigned max_run);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        len = $urandom_range(1, max_run);
        send_run(1'b1, len);
        sent += len;
        len = $urandom_range(1, max_run);
        send_run(1'b0, len);
        sent += len;
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) send_tick(1'($urandom));
        sent += len;
      end
    end
  endtask

  initial begin : stimulus
    logic [EnCntW-1:0]  ed;
    logic [RfCntW-1:0]  rp;
    logic [DisCntW-1:0] dd;
    int unsigned        max_run;

    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_data_i           = '0;
    in_ch.valid          = 1'b0;
    in_ch.output_allowed = 1'b0;
    tx_gaps_on           = 1'b1;
    rx_stalls_on         = 1'b1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset register values: no command within the first ticks
    send_run(1'b1, 80);
    send_run(1'b0, 5);
    send_run(1'b1, 5);
    drain_results();

    // enable delay lowered below the running count: next allowed tick enables
    configure(16'd2, 8'd3, 10'd2);
    send_run(1'b1, 4);
    send_tick(1'b0);
    send_tick(1'b1);
    send_run(1'b0, 4);
    send_tick(1'b1);
    send_tick(1'b0);
    send_run(1'b1, 2);
    send_tick(1'b0);
    drain_results();

    // all registers zero: each event fires on its first counted tick
    configure(16'd0, 8'd0, 10'd0);
    send_tick(1'b0);
    send_run(1'b1, 3);
    send_tick(1'b0);
    drain_results();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
      case (p)
        0: begin ed = 16'd1; rp = 8'd1; dd = 10'd1; end
        2: begin
          ed = 16'($urandom_range(0, 3));
          rp = 8'($urandom_range(0, 2));
          dd = 10'($urandom_range(0, 3));
        end
        3: begin ed = 16'hFFFF; rp = 8'hFF; dd = 10'h3FF; end
        5: begin
          ed = 16'($urandom_range(1, 10));
          rp = 8'hFF;
          dd = 10'($urandom_range(1, 10));
        end
        default: begin
          ed = 16'($urandom_range(1, 20));
          rp = 8'($urandom_range(1, 8));
          dd = 10'($urandom_range(1, 20));
        end
      endcase
      configure(ed, rp, dd);
      max_run = 2 * ((ed > dd) ? ed : dd) + 4;
      if (p == 3) begin
        // largest register values: nothing fires within a short run
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        send_run(1'b1, 60);
        send_run(1'b0, 10);
        send_run(1'b1, 3);
      end else begin
        if (p == 4) begin
          tx_gaps_on   = 1'b0;
          rx_stalls_on = 1'b0;
        end
        if (p == 1) begin
          tx_gaps_on  = 1'b0;
          rx_hold_req = ~rx_hold_req;
        end
        run_sequences(60, max_run);
        drain_results();
        run_sequences(60, max_run);
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("supercap_enable_sequencer_unit test passed");
    end else begin
      $display("supercap_enable_sequencer_unit test failed");
    end
    $finish;
  end

endmodule

/* supercap_enable_sequencer_unit.f */
sv/sces_pkg.sv
sv/sces_stream_if.sv
sv/sces_cfg_regs.sv
sv/sces_core.sv
sv/supercap_enable_sequencer_unit.sv
verif/testbench.sv
